>>> rtl/core/kcl_pkg.sv
package kcl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        KIND_APPEND  = 3'd0,
        KIND_PREPEND = 3'd1,
        KIND_INSERT  = 3'd2,
        KIND_DELETE  = 3'd3,
        KIND_UPDATE  = 3'd4,
        KIND_PRINT   = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ST_DONE     = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PRINT,
        S_COMMIT,
        S_OUT
    } state_t;

    // Node memory access port driven by the controller.
    typedef struct packed {
        logic             wr_node;
        logic             wr_data;
        logic             wr_link;
        logic [IDX_W-1:0] waddr;
        logic [31:0]      wkey;
        logic [31:0]      wdata;
        logic [IDX_W-1:0] wlink;
        logic [IDX_W-1:0] raddr;
    } mem_req_t;

endpackage

>>> rtl/core/kcl_node_mem.sv
module kcl_node_mem (
    input  logic                           aclk,
    input  kcl_pkg::mem_req_t              req,
    output logic [31:0]                    rd_key,
    output logic [31:0]                    rd_data,
    output logic [kcl_pkg::IDX_W-1:0]      rd_link
);

    logic [31:0]               key_mem  [kcl_pkg::CAPACITY];
    logic [31:0]               data_mem [kcl_pkg::CAPACITY];
    logic [kcl_pkg::IDX_W-1:0] link_mem [kcl_pkg::CAPACITY];

    // One write port per field, one registered read port.
    always_ff @(posedge aclk) begin
        if (req.wr_node) begin
            key_mem[req.waddr] <= req.wkey;
        end
        if (req.wr_node || req.wr_data) begin
            data_mem[req.waddr] <= req.wdata;
        end
        if (req.wr_link) begin
            link_mem[req.waddr] <= req.wlink;
        end
        rd_key  <= key_mem[req.raddr];
        rd_data <= data_mem[req.raddr];
        rd_link <= link_mem[req.raddr];
    end

endmodule

>>> rtl/core/keyed_circular_list_engine_top.sv
// Keyed circular list engine.
// Input channel s_*: one beat is one operation (kind, new_key, search_key,
// new_data). Result channel m_*: beats carry status, out_key, out_data, last
// and list_size. Each append, prepend, insert, delete or update gives one
// beat; print gives one beat per node from the head, or one beat with
// status empty; kinds 6 and 7 are accepted and give no beat.
// Nodes live in a node memory with one registered read port. Each
// operation walks the list from the head, each node first addressed and
// then examined from the registered data. One operation is processed at a
// time; s_ready is high only when the engine is idle and its result
// register is empty.
// Reset (aresetn low, synchronous) empties the list and frees all slots;
// the node memory contents need no clearing since free slots are never read.
// When the receiver stalls, the result beat is held in the output register
// and the walk pauses.
module keyed_circular_list_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_kind,
    input  logic signed [31:0] s_new_key,
    input  logic signed [31:0] s_search_key,
    input  logic signed [31:0] s_new_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic signed [31:0] m_out_key,
    output logic signed [31:0] m_out_data,
    output logic        m_last,
    output logic [4:0]  m_list_size
);

    localparam int IW = kcl_pkg::IDX_W;
    localparam int CW = kcl_pkg::CNT_W;

    kcl_pkg::state_t state_reg, state_next;
    kcl_pkg::mem_req_t req;
    logic [31:0]   rd_key, rd_data;
    logic [IW-1:0] rd_link;

    kcl_node_mem u_mem (
        .aclk   (aclk),
        .req    (req),
        .rd_key (rd_key),
        .rd_data(rd_data),
        .rd_link(rd_link)
    );

    // Control and payload registers.
    logic [kcl_pkg::CAPACITY-1:0] used_reg, used_next;
    logic [IW-1:0] head_reg, head_next;
    logic [CW-1:0] total_reg, total_next;
    logic [2:0]    kind_reg;
    logic [31:0]   nkey_reg, skey_reg, ndata_reg;
    logic [IW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          phase_reg, phase_next;   // 1 when memory data is valid
    logic          dup_reg, dup_next, fnd_reg, fnd_next;
    logic [IW-1:0] spos_reg, spos_next, spred_reg, spred_next, snext_reg, snext_next;
    logic [31:0]   skdata_reg, skdata_next; // data of found search node
    logic [31:0]   dkey_reg, dkey_next, ddata_reg, ddata_next;
    logic [IW-1:0] tail_reg, tail_next;
    logic          mv_reg, mv_next, ml_reg, ml_next;
    logic [2:0]    ms_reg, ms_next;
    logic [31:0]   mk_reg, mk_next, md_reg, md_next;
    // Slot picked at commit, kept for the second link write.
    logic [IW-1:0] free_idx_reg;

    // Lowest free slot.
    logic          free_ok;
    logic [IW-1:0] free_idx;
    always_comb begin
        free_ok  = 1'b0;
        free_idx = '0;
        for (int i = kcl_pkg::CAPACITY - 1; i >= 0; i--) begin
            if (!used_reg[i]) begin
                free_ok  = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    logic accept;
    assign s_ready = (state_reg == kcl_pkg::S_IDLE) && !mv_reg;
    assign accept  = s_valid && s_ready;
    logic out_free;
    assign out_free = !mv_reg || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            kcl_pkg::S_IDLE: begin
                if (accept) begin
                    if (s_kind == kcl_pkg::KIND_PRINT) begin
                        state_next = kcl_pkg::S_PRINT;
                    end else if (s_kind <= kcl_pkg::KIND_UPDATE) begin
                        state_next = (total_reg == '0) ? kcl_pkg::S_COMMIT
                                                       : kcl_pkg::S_WALK;
                    end
                end
            end
            kcl_pkg::S_WALK: begin
                if (phase_reg && cnt_reg == total_reg - CW'(1)) begin
                    state_next = kcl_pkg::S_COMMIT;
                end
            end
            kcl_pkg::S_PRINT: begin
                if (total_reg == '0) begin
                    if (out_free) state_next = kcl_pkg::S_IDLE;
                end else if (phase_reg && out_free && cnt_reg == total_reg - CW'(1)) begin
                    state_next = kcl_pkg::S_IDLE;
                end
            end
            kcl_pkg::S_COMMIT: state_next = kcl_pkg::S_OUT;
            kcl_pkg::S_OUT: begin
                if (out_free) state_next = kcl_pkg::S_IDLE;
            end
            default: state_next = kcl_pkg::S_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        used_next = used_reg;   head_next = head_reg;   total_next = total_reg;
        cur_next = cur_reg;     prev_next = prev_reg;   cnt_next = cnt_reg;
        phase_next = phase_reg; dup_next = dup_reg;     fnd_next = fnd_reg;
        spos_next = spos_reg;   spred_next = spred_reg;
        snext_next = snext_reg; skdata_next = skdata_reg;
        dkey_next = dkey_reg;   ddata_next = ddata_reg;
        tail_next = tail_reg;
        mv_next = mv_reg;       ml_next = ml_reg;       ms_next = ms_reg;
        mk_next = mk_reg;       md_next = md_reg;
        req = '0;
        req.raddr = cur_reg;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (state_reg)
            kcl_pkg::S_IDLE: begin
                cur_next = head_reg; cnt_next = '0; phase_next = 1'b0;
                dup_next = 1'b0; fnd_next = 1'b0;
                req.raddr = head_reg;
            end
            kcl_pkg::S_WALK: begin
                if (!phase_reg) begin
                    phase_next = 1'b1;
                end else begin
                    // Examine the node just read.
                    if (kind_reg <= kcl_pkg::KIND_INSERT && rd_key == nkey_reg
                            && !dup_reg) begin
                        dup_next = 1'b1;
                        dkey_next = rd_key; ddata_next = rd_data;
                    end
                    if (rd_key == skey_reg && !fnd_reg) begin
                        fnd_next = 1'b1; spos_next = cur_reg;
                        spred_next = prev_reg; snext_next = rd_link;
                        skdata_next = rd_data;
                    end
                    // Predecessor of the head is the tail.
                    if (cnt_reg == total_reg - CW'(1)) begin
                        tail_next = cur_reg;
                        if (!fnd_reg && rd_key != skey_reg) spred_next = cur_reg;
                        else if (fnd_reg && spos_reg == head_reg)
                            spred_next = cur_reg;
                        else if (!fnd_reg && cnt_reg == '0)
                            spred_next = cur_reg;
                    end
                    prev_next = cur_reg; cur_next = rd_link;
                    cnt_next = cnt_reg + CW'(1); phase_next = 1'b0;
                    req.raddr = rd_link;
                end
            end
            kcl_pkg::S_PRINT: begin
                if (total_reg == '0) begin
                    if (out_free) begin
                        mv_next = 1'b1; ms_next = kcl_pkg::ST_EMPTY;
                        mk_next = '0; md_next = '0; ml_next = 1'b1;
                    end
                end else if (!phase_reg) begin
                    phase_next = 1'b1;
                end else if (out_free) begin
                    mv_next = 1'b1; ms_next = kcl_pkg::ST_DONE;
                    mk_next = rd_key; md_next = rd_data;
                    ml_next = (cnt_reg == total_reg - CW'(1));
                    cur_next = rd_link; cnt_next = cnt_reg + CW'(1);
                    phase_next = 1'b0; req.raddr = rd_link;
                end else begin
                    req.raddr = cur_reg;
                end
            end
            kcl_pkg::S_COMMIT: begin
                ml_next = 1'b1;
                mk_next = skey_reg; md_next = '0;
                ms_next = kcl_pkg::ST_NOTFOUND;
                if (kind_reg <= kcl_pkg::KIND_INSERT) begin
                    if (dup_reg) begin
                        ms_next = kcl_pkg::ST_DUP;
                        mk_next = dkey_reg; md_next = ddata_reg;
                    end else if (kind_reg == kcl_pkg::KIND_INSERT && !fnd_reg) begin
                        ms_next = kcl_pkg::ST_NOTFOUND;
                    end else if (!free_ok) begin
                        ms_next = kcl_pkg::ST_FULL;
                        mk_next = nkey_reg; md_next = ndata_reg;
                    end else begin
                        ms_next = kcl_pkg::ST_DONE;
                        mk_next = nkey_reg; md_next = ndata_reg;
                        used_next[free_idx] = 1'b1;
                        total_next = total_reg + CW'(1);
                        req.wr_node = 1'b1; req.wr_link = 1'b1;
                        req.waddr = free_idx; req.wkey = nkey_reg;
                        req.wdata = ndata_reg;
                        if (total_reg == '0) begin
                            head_next = free_idx; req.wlink = free_idx;
                        end else if (kind_reg == kcl_pkg::KIND_INSERT) begin
                            req.wlink = snext_reg;
                        end else begin
                            req.wlink = head_reg;
                            if (kind_reg == kcl_pkg::KIND_PREPEND)
                                head_next = free_idx;
                        end
                    end
                end else if (kind_reg == kcl_pkg::KIND_DELETE) begin
                    if (total_reg == '0) begin
                        ms_next = kcl_pkg::ST_EMPTY; mk_next = '0;
                    end else if (fnd_reg) begin
                        ms_next = kcl_pkg::ST_DONE;
                        mk_next = skey_reg; md_next = skdata_reg;
                        used_next[spos_reg] = 1'b0;
                        total_next = total_reg - CW'(1);
                        if (total_reg == CW'(1)) begin
                            head_next = '0;
                        end else begin
                            req.wr_link = 1'b1; req.waddr = spred_reg;
                            req.wlink = snext_reg;
                            if (spos_reg == head_reg) head_next = snext_reg;
                        end
                    end
                end else begin
                    if (fnd_reg) begin
                        ms_next = kcl_pkg::ST_DONE;
                        mk_next = skey_reg; md_next = ndata_reg;
                        req.wr_data = 1'b1; req.waddr = spos_reg;
                        req.wdata = ndata_reg;
                    end
                end
            end
            kcl_pkg::S_OUT: begin
                // Second link write for add operations.
                if (ms_reg == kcl_pkg::ST_DONE && kind_reg <= kcl_pkg::KIND_INSERT
                        && total_reg != CW'(1)) begin
                    req.wr_link = 1'b1;
                    req.waddr = (kind_reg == kcl_pkg::KIND_INSERT) ? spos_reg : tail_reg;
                    req.wlink = free_idx_reg;
                end
                if (out_free) mv_next = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (state_reg == kcl_pkg::S_COMMIT) free_idx_reg <= free_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kcl_pkg::S_IDLE;
            used_reg  <= '0;
            head_reg  <= '0;
            total_reg <= '0;
            mv_reg    <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            total_reg <= total_next;
            mv_reg    <= mv_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            kind_reg <= s_kind; nkey_reg <= s_new_key;
            skey_reg <= s_search_key; ndata_reg <= s_new_data;
        end
        cur_reg <= cur_next; prev_reg <= prev_next; cnt_reg <= cnt_next;
        dup_reg <= dup_next; fnd_reg <= fnd_next;
        spos_reg <= spos_next; spred_reg <= spred_next; snext_reg <= snext_next;
        skdata_reg <= skdata_next; dkey_reg <= dkey_next; ddata_reg <= ddata_next;
        tail_reg <= tail_next;
        ml_reg <= ml_next; ms_reg <= ms_next; mk_reg <= mk_next; md_reg <= md_next;
    end

    assign m_valid     = mv_reg;
    assign m_status    = ms_reg;
    assign m_out_key   = mk_reg;
    assign m_out_data  = md_reg;
    assign m_last      = ml_reg;
    assign m_list_size = 5'(total_reg);

endmodule

>>> test/tb_keyed_circular_list_engine_top.sv
module tb_keyed_circular_list_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]  kind;
        logic [31:0] nkey;
        logic [31:0] skey;
        logic [31:0] ndata;
    } op_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] okey;
        logic [31:0] odata;
        logic        lst;
        logic [4:0]  size;
    } res_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [2:0]  s_kind;
    logic signed [31:0] s_new_key;
    logic signed [31:0] s_search_key;
    logic signed [31:0] s_new_data;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic signed [31:0] m_out_key;
    logic signed [31:0] m_out_data;
    logic        m_last;
    logic [4:0]  m_list_size;

    keyed_circular_list_engine_top DUT (.*);

    // Predictor state: the list is kept as an ordered queue of nodes from the head.
    logic [31:0] list_keys[$];
    logic [31:0] list_data[$];

    op_t  pending_ops[$];
    res_t expected_beats[$];
    int   fail_count = 0;
    int   beats_seen = 0;
    int   ops_sent = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    // Accept flag captured at the rising edge so the driver knows the beat left.
    logic s_ready_q = 1'b0;

    // Linear key search; returns -1 when the key is absent.
    function automatic int find_key(logic [31:0] k);
        foreach (list_keys[i])
            if (list_keys[i] == k)
                return i;
        return -1;
    endfunction

    function automatic void push_beat(logic [2:0] st, logic [31:0] k, logic [31:0] d,
                                      logic l);
        res_t r;
        r.status = st;
        r.okey = k;
        r.odata = d;
        r.lst = l;
        r.size = 5'(list_keys.size());
        expected_beats.push_back(r);
    endfunction

    // Apply one operation to the list and queue the beats it produces.
    function automatic void apply_list_op(op_t op);
        int p;
        int a;
        p = find_key(op.nkey);
        case (op.kind)
            kcl_pkg::KIND_APPEND, kcl_pkg::KIND_PREPEND, kcl_pkg::KIND_INSERT: begin
                a = find_key(op.skey);
                if (p >= 0)
                    push_beat(kcl_pkg::ST_DUP, list_keys[p], list_data[p], 1'b1);
                else if (op.kind == kcl_pkg::KIND_INSERT && a < 0)
                    push_beat(kcl_pkg::ST_NOTFOUND, op.skey, 32'd0, 1'b1);
                else if (list_keys.size() >= kcl_pkg::CAPACITY)
                    push_beat(kcl_pkg::ST_FULL, op.nkey, op.ndata, 1'b1);
                else begin
                    if (op.kind == kcl_pkg::KIND_APPEND) begin
                        list_keys.push_back(op.nkey);
                        list_data.push_back(op.ndata);
                    end else if (op.kind == kcl_pkg::KIND_PREPEND) begin
                        list_keys.push_front(op.nkey);
                        list_data.push_front(op.ndata);
                    end else begin
                        list_keys.insert(a + 1, op.nkey);
                        list_data.insert(a + 1, op.ndata);
                    end
                    push_beat(kcl_pkg::ST_DONE, op.nkey, op.ndata, 1'b1);
                end
            end
            kcl_pkg::KIND_DELETE: begin
                a = find_key(op.skey);
                if (list_keys.size() == 0)
                    push_beat(kcl_pkg::ST_EMPTY, 32'd0, 32'd0, 1'b1);
                else if (a < 0)
                    push_beat(kcl_pkg::ST_NOTFOUND, op.skey, 32'd0, 1'b1);
                else begin
                    logic [31:0] k;
                    logic [31:0] d;
                    k = list_keys[a];
                    d = list_data[a];
                    list_keys.delete(a);
                    list_data.delete(a);
                    push_beat(kcl_pkg::ST_DONE, k, d, 1'b1);
                end
            end
            kcl_pkg::KIND_UPDATE: begin
                a = find_key(op.skey);
                if (a < 0)
                    push_beat(kcl_pkg::ST_NOTFOUND, op.skey, 32'd0, 1'b1);
                else begin
                    list_data[a] = op.ndata;
                    push_beat(kcl_pkg::ST_DONE, list_keys[a], op.ndata, 1'b1);
                end
            end
            kcl_pkg::KIND_PRINT: begin
                if (list_keys.size() == 0)
                    push_beat(kcl_pkg::ST_EMPTY, 32'd0, 32'd0, 1'b1);
                else
                    foreach (list_keys[i])
                        push_beat(kcl_pkg::ST_DONE, list_keys[i], list_data[i],
                                  i == list_keys.size() - 1);
            end
            default: ;
        endcase
    endfunction

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Driver: presents queued operations at the falling edge.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_kind <= '0;
            s_new_key <= '0;
            s_search_key <= '0;
            s_new_data <= '0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || s_ready_q) begin
                if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    op_t op;
                    op = pending_ops.pop_front();
                    s_valid <= 1'b1;
                    s_kind <= op.kind;
                    s_new_key <= op.nkey;
                    s_search_key <= op.skey;
                    s_new_data <= op.ndata;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: predicts on accepted operations and checks result beats.
    always @(posedge aclk) begin
        s_ready_q <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                op_t op;
                op.kind = s_kind;
                op.nkey = s_new_key;
                op.skey = s_search_key;
                op.ndata = s_new_data;
                apply_list_op(op);
                ops_sent++;
            end
            if (m_valid && m_ready) begin
                beats_seen++;
                if (expected_beats.size() == 0) begin
                    $error("result beat with no expectation: key %h", m_out_key);
                    fail_count++;
                end else begin
                    res_t e;
                    e = expected_beats.pop_front();
                    if (m_status !== e.status) begin
                        $error("status expected %0d actual %0d", e.status, m_status);
                        fail_count++;
                    end
                    if (m_out_key !== e.okey) begin
                        $error("out_key expected %h actual %h", e.okey, m_out_key);
                        fail_count++;
                    end
                    if (m_out_data !== e.odata) begin
                        $error("out_data expected %h actual %h", e.odata, m_out_data);
                        fail_count++;
                    end
                    if (m_last !== e.lst) begin
                        $error("last expected %0d actual %0d", e.lst, m_last);
                        fail_count++;
                    end
                    if (m_list_size !== e.size) begin
                        $error("list_size expected %0d actual %0d", e.size, m_list_size);
                        fail_count++;
                    end
                end
            end
        end
    end

    function automatic void queue_op(logic [2:0] kind, logic [31:0] nkey,
                                     logic [31:0] skey, logic [31:0] ndata);
        op_t op;
        op.kind = kind;
        op.nkey = nkey;
        op.skey = skey;
        op.ndata = ndata;
        pending_ops.push_back(op);
    endfunction

    // Keys from a small pool so that hits, duplicates and misses all happen.
    function automatic logic [31:0] pool_key();
        if ($urandom_range(9) == 0)
            return $urandom();
        return 32'h5A00_0000 ^ $urandom_range(23);
    endfunction

    task automatic wait_drained();
        while (pending_ops.size() > 0 || s_valid || expected_beats.size() > 0)
            @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    initial begin
        int n;
        int k;
        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-list cases, extremes, duplicates, full pool, head delete.
        queue_op(kcl_pkg::KIND_PRINT, 0, 0, 0);
        queue_op(kcl_pkg::KIND_DELETE, 0, 32'h1234, 0);
        queue_op(kcl_pkg::KIND_UPDATE, 0, 32'h1234, 0);
        queue_op(kcl_pkg::KIND_INSERT, 32'h7, 32'h9, 32'h1);
        queue_op(kcl_pkg::KIND_APPEND, 32'h8000_0000, 0, 32'h7FFF_FFFF);
        queue_op(kcl_pkg::KIND_PREPEND, 32'h7FFF_FFFF, 0, 32'h8000_0000);
        queue_op(kcl_pkg::KIND_APPEND, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        queue_op(kcl_pkg::KIND_INSERT, 32'h0, 32'h7FFF_FFFF, 32'h0);
        queue_op(kcl_pkg::KIND_APPEND, 32'h8000_0000, 0, 32'h55);
        queue_op(kcl_pkg::KIND_INSERT, 32'h0, 32'h42, 32'h0);
        queue_op(kcl_pkg::KIND_UPDATE, 0, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
        queue_op(kcl_pkg::KIND_PRINT, 0, 0, 0);
        queue_op(3'd6, 32'h1, 32'h1, 32'h1);
        queue_op(3'd7, 32'h2, 32'h2, 32'h2);
        queue_op(kcl_pkg::KIND_DELETE, 0, 32'h7FFF_FFFF, 0);
        queue_op(kcl_pkg::KIND_DELETE, 0, 32'h4444, 0);
        for (int i = 0; i < 14; i++)
            queue_op(kcl_pkg::KIND_APPEND, 32'h100 + i, 0, 32'h200 + i);
        queue_op(kcl_pkg::KIND_APPEND, 32'h999, 0, 32'h999);
        queue_op(kcl_pkg::KIND_INSERT, 32'h100, 32'h101, 0);
        queue_op(kcl_pkg::KIND_PRINT, 0, 0, 0);
        wait_drained();

        // Random phases with different idle and stall patterns.
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 84; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 84; end
                3: begin send_idle_pct = 26; recv_stall_pct = 26; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            for (n = 0; n < 67; n++) begin
                k = $urandom_range(99);
                if (k < 10)
                    queue_op(3'($urandom_range(7, 6)), $urandom(), $urandom(), $urandom());
                else if (k < 40)
                    queue_op(3'($urandom_range(2)), pool_key(), pool_key(), $urandom());
                else if (k < 65)
                    queue_op(kcl_pkg::KIND_DELETE, $urandom(), pool_key(), $urandom());
                else if (k < 85)
                    queue_op(kcl_pkg::KIND_UPDATE, $urandom(), pool_key(), $urandom());
                else
                    queue_op(kcl_pkg::KIND_PRINT, $urandom(), $urandom(), $urandom());
            end
            wait_drained();
        end

        $display("Ran %0d operations, %0d result beats checked, under four idle patterns.",
                 ops_sent, beats_seen);
        if (fail_count == 0 && expected_beats.size() == 0)
            $display("tb_keyed_circular_list_engine_top OK");
        else
            $display("tb_keyed_circular_list_engine_top NOT OK");
        $finish;
    end

    // Watchdog.
    initial begin
        #8ms;
        $display("tb_keyed_circular_list_engine_top NOT OK");
        $finish;
    end

endmodule
